// ===== src/cfrc_pkg.sv =====
// Shared definitions for the command frame receiver and checker.
// Holds frame constants, the status code type, the per-frame state view and
// the byte-wide CRC-16/XMODEM update. No dependencies.
`default_nettype none

package cfrc_pkg;

   localparam logic [7:0]  FRAME_HEADER     = 8'h5A;
   localparam logic [7:0]  CMD_DEVICE_STATE = 8'h89;
   localparam logic [7:0]  CMD_OFFSET       = 8'h90;
   localparam logic [15:0] LENGTH_OVERHEAD  = 16'd3;
   localparam int          STATE_BYTES      = 10;
   localparam int          CAPTURE_FIRST    = 4;
   localparam logic [15:0] CRC_POLY         = 16'h1021;
   localparam logic [15:0] COUNT_MAX        = 16'hFFFF;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_HEADER = 2'd1,
      STATUS_LENGTH = 2'd2,
      STATUS_CRC    = 2'd3
   } frame_status_type;

   // Frame tracking state as it stands once the current byte is taken in.
   typedef struct packed {
      logic                         header_good;
      logic [15:0]                  byte_count;
      logic [15:0]                  declared_length;
      logic [7:0]                   command_byte;
      logic [15:0]                  running_crc;
      logic [15:0]                  last_two_bytes;
      logic [STATE_BYTES-1:0][7:0]  capture;
   } frame_view_type;

   // One byte of CRC-16/XMODEM: MSB first, eight shift steps.
   function automatic logic [15:0] crc_xmodem_byte(input logic [15:0] crc,
                                                   input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {data, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

endpackage

`default_nettype wire

// ===== src/cfrc_parser.sv =====
// Frame parser: tracks header, declared length, command, running CRC, the
// last two bytes and the captured data bytes of the current burst.
// Depends on cfrc_pkg.
`default_nettype none

module cfrc_parser (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     step,
   input  wire logic [7:0]               rx_byte,
   input  wire logic                     burst_end,
   output cfrc_pkg::frame_view_type      view
);

   logic        header_good_ff, header_good_in;
   logic [15:0] byte_count_ff, byte_count_in;
   logic [15:0] declared_length_ff, declared_length_in;
   logic [7:0]  command_byte_ff, command_byte_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] last_two_bytes_ff, last_two_bytes_in;
   logic [cfrc_pkg::STATE_BYTES-1:0][7:0] capture_ff, capture_in;

   always_comb begin
      logic [15:0] idx;
      idx                = byte_count_ff;
      header_good_in     = header_good_ff;
      byte_count_in      = byte_count_ff;
      declared_length_in = declared_length_ff;
      command_byte_in    = command_byte_ff;
      running_crc_in     = running_crc_ff;
      capture_in         = capture_ff;
      if (idx != cfrc_pkg::COUNT_MAX) begin
         if (idx == 16'd0) begin
            header_good_in = (rx_byte == cfrc_pkg::FRAME_HEADER);
         end
         if (idx == 16'd1) begin
            declared_length_in[15:8] = rx_byte;
         end
         if (idx == 16'd2) begin
            declared_length_in[7:0] = rx_byte;
         end
         if (idx == 16'd3) begin
            command_byte_in = rx_byte;
         end
         if (idx >= 16'd3 && idx <= declared_length_in) begin
            running_crc_in = cfrc_pkg::crc_xmodem_byte(running_crc_ff, rx_byte);
         end
         for (int k = 0; k < cfrc_pkg::STATE_BYTES; k++) begin
            if (idx == 16'(k + cfrc_pkg::CAPTURE_FIRST)) begin
               capture_in[k] = rx_byte;
            end
         end
         byte_count_in = idx + 16'd1;
      end
      last_two_bytes_in = {last_two_bytes_ff[7:0], rx_byte};
   end

   assign view.header_good     = header_good_in;
   assign view.byte_count      = byte_count_in;
   assign view.declared_length = declared_length_in;
   assign view.command_byte    = command_byte_in;
   assign view.running_crc     = running_crc_in;
   assign view.last_two_bytes  = last_two_bytes_in;
   assign view.capture         = capture_in;

   // A closing byte clears the frame state; captured data is kept.
   always_ff @(posedge clock) begin
      if (reset) begin
         header_good_ff     <= 1'b0;
         byte_count_ff      <= '0;
         declared_length_ff <= '0;
         command_byte_ff    <= '0;
         running_crc_ff     <= '0;
         last_two_bytes_ff  <= '0;
      end else if (step) begin
         if (burst_end) begin
            header_good_ff     <= 1'b0;
            byte_count_ff      <= '0;
            declared_length_ff <= '0;
            command_byte_ff    <= '0;
            running_crc_ff     <= '0;
            last_two_bytes_ff  <= '0;
         end else begin
            header_good_ff     <= header_good_in;
            byte_count_ff      <= byte_count_in;
            declared_length_ff <= declared_length_in;
            command_byte_ff    <= command_byte_in;
            running_crc_ff     <= running_crc_in;
            last_two_bytes_ff  <= last_two_bytes_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         capture_ff <= capture_in;
      end
   end

endmodule

`default_nettype wire

// ===== src/command_frame_receiver_checker.sv =====
// A word accepted into the input register is parsed from there; the word
// that closes a burst shows its result on rsp_ from the result register.
// Throughput: one word per cycle, set by the single parse stage between the
// input register and the result register; a waiting result stalls only a
// closing word. Reset clears frame state, records and valid flags and sets
// CRC checking on. Depends on cfrc_pkg and cfrc_parser.
`default_nettype none

module command_frame_receiver_checker (
   input  wire logic          clock,
   input  wire logic          reset,
   // Received bytes.
   input  wire logic          req_tvalid,
   output      logic          req_tready,
   input  wire logic [7:0]    req_tdata,   // [7:0] rx_byte
   input  wire logic          req_tlast,   // burst_end
   // Frame reports.
   output      logic          rsp_tvalid,
   input  wire logic          rsp_tready,
   // [7:0] command, [23:8] data_length, [24] device_state_updated,
   // [25] offset_updated, [89:26] device_state_low,
   // [105:90] device_state_high, [129:106] offset_xyz, [135:130] zero
   output      logic [135:0]  rsp_tdata,
   output      logic [1:0]    rsp_tuser,   // [1:0] frame_status
   // Control register: crc_check_enable.
   input  wire logic          csr_valid,
   output      logic          csr_ready,
   input  wire logic [0:0]    csr_data
);

   // The control register is always writable.
   logic crc_enable_ff;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_enable_ff <= 1'b1;
      end else if (csr_valid) begin
         crc_enable_ff <= csr_data[0];
      end
   end

   // Input register. A word that does not close a burst always moves on; a
   // closing word waits until the result register has room.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       advance;
   logic       out_room;

   assign out_room   = !rsp_tvalid || rsp_tready;
   assign advance    = in_valid_ff && (!in_last_ff || out_room);
   assign req_tready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   cfrc_pkg::frame_view_type view;

   cfrc_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .rx_byte   (in_byte_ff),
      .burst_end (in_last_ff),
      .view      (view)
   );

   // Frame verdict, evaluated from the state that includes the current byte.
   cfrc_pkg::frame_status_type status;
   logic [7:0]  cmd_out;
   logic [15:0] len_out;
   logic        dev_upd, off_upd;
   logic [16:0] count_wide, need_wide;

   assign count_wide = {1'b0, view.byte_count};
   assign need_wide  = {1'b0, view.declared_length} + {1'b0, cfrc_pkg::LENGTH_OVERHEAD};

   always_comb begin
      status  = cfrc_pkg::STATUS_OK;
      cmd_out = '0;
      len_out = '0;
      dev_upd = 1'b0;
      off_upd = 1'b0;
      if (!view.header_good) begin
         status = cfrc_pkg::STATUS_HEADER;
      end else begin
         if (view.byte_count >= 16'd4) begin
            cmd_out = view.command_byte;
         end
         if (view.declared_length >= cfrc_pkg::LENGTH_OVERHEAD) begin
            len_out = view.declared_length - cfrc_pkg::LENGTH_OVERHEAD;
         end
         if (view.byte_count < 16'd3 ||
             view.declared_length < cfrc_pkg::LENGTH_OVERHEAD ||
             count_wide < need_wide) begin
            status = cfrc_pkg::STATUS_LENGTH;
         end else if (crc_enable_ff && view.running_crc != view.last_two_bytes) begin
            status = cfrc_pkg::STATUS_CRC;
         end else begin
            // Only the device-state command needs a full record of data.
            if (view.command_byte == cfrc_pkg::CMD_DEVICE_STATE) begin
               dev_upd = (len_out >= 16'(cfrc_pkg::STATE_BYTES));
            end else if (view.command_byte == cfrc_pkg::CMD_OFFSET) begin
               off_upd = 1'b1;
            end
         end
      end
   end

   // Records. The report always shows them as they stand after this frame.
   logic [cfrc_pkg::STATE_BYTES-1:0][7:0] dev_record_ff, dev_record_in;
   logic [2:0][7:0]                      off_record_ff, off_record_in;
   logic                                 close_step;

   assign close_step    = advance && in_last_ff;
   assign dev_record_in = dev_upd ? view.capture : dev_record_ff;
   assign off_record_in = off_upd ? view.capture[2:0] : off_record_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_record_ff <= '0;
         off_record_ff <= '0;
      end else if (close_step) begin
         dev_record_ff <= dev_record_in;
         off_record_ff <= off_record_in;
      end
   end

   // Result register.
   logic         rsp_valid_ff;
   logic [135:0] rsp_data_ff;
   logic [1:0]   rsp_user_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (close_step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (close_step) begin
         rsp_user_ff <= status;
         rsp_data_ff <= {6'd0, off_record_in, dev_record_in, off_upd, dev_upd,
                         len_out, cmd_out};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== src/cfrc_checker.sv =====
// Port-level checks for the command frame receiver and checker, attached to
// the top level by the bind below. Depends on cfrc_pkg for status and command codes.
`default_nettype none

module cfrc_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          rsp_tvalid,
   input wire logic          rsp_tready,
   input wire logic [135:0]  rsp_tdata,
   input wire logic [1:0]    rsp_tuser
);

   // A stalled report holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("report changed while stalled");

   // A bad header reports no command and no length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == cfrc_pkg::STATUS_HEADER |-> rsp_tdata[23:0] == 24'd0)
      else $error("bad header report carries command or length");

   // Record updates happen only on good frames, never both at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[24] || rsp_tdata[25]) |->
         rsp_tuser == cfrc_pkg::STATUS_OK && !(rsp_tdata[24] && rsp_tdata[25]))
      else $error("record update on a failed frame");

   // A device-state update needs its command and a full record of data.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |->
         rsp_tdata[7:0] == cfrc_pkg::CMD_DEVICE_STATE &&
         rsp_tdata[23:8] >= 16'(cfrc_pkg::STATE_BYTES))
      else $error("device-state update without a full record");

endmodule

bind command_frame_receiver_checker cfrc_checker u_cfrc_checker (.*);

`default_nettype wire

// ===== tb/frame_report_checker.sv =====
// Checker for the command frame receiver: watches the byte, report and control
// channels, predicts each frame report and compares it field by field.
// Depends on cfrc_pkg for the frame constants and the status code type.
module frame_report_checker
   import cfrc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [7:0]    req_tdata,   // [7:0] rx_byte
   input  logic          req_tlast,   // burst_end
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   // [7:0] command, [23:8] data_length, [24] device_state_updated,
   // [25] offset_updated, [89:26] device_state_low,
   // [105:90] device_state_high, [129:106] offset_xyz, [135:130] zero
   input  logic [135:0]  rsp_tdata,
   input  logic [1:0]    rsp_tuser,   // [1:0] frame_status
   input  logic          csr_valid,
   input  logic          csr_ready,
   input  logic [0:0]    csr_data,
   output int unsigned   mismatches,
   output logic [31:0]   pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      frame_status_type status;
      logic [7:0]       command;
      logic [15:0]      data_length;
      logic             state_updated;
      logic             offset_updated;
      logic [63:0]      state_low;
      logic [15:0]      state_high;
      logic [23:0]      offsets;
   } frame_report_type;

   frame_report_type expected_reports[$];
   int unsigned      reports_seen;

   // Mirror of the receiver state.
   logic        crc_enable;
   logic [15:0] fill;
   logic [15:0] decl_len;
   logic        hdr_ok;
   logic [7:0]  cmd_byte;
   logic [15:0] crc_acc;
   logic [15:0] tail;
   logic [7:0]  capture [STATE_BYTES];
   logic [7:0]  state_rec [STATE_BYTES];
   logic [7:0]  offset_rec [3];

   // Bit-serial CRC-16/XMODEM, most significant bit first.
   function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      logic        feedback;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[15] ^ b[i];
         c = {c[14:0], 1'b0};
         if (feedback) begin
            c = c ^ 16'h1021;
         end
      end
      return c;
   endfunction

   task automatic clear_frame();
      fill = '0;
      decl_len = '0;
      hdr_ok = 1'b0;
      cmd_byte = '0;
      crc_acc = '0;
      tail = '0;
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] want,
                                  input logic [63:0] seen);
      mismatches++;
      $display("%0t ns report %0d: %s expected %h, seen %h",
               $time, reports_seen, what, want, seen);
   endtask

   // Takes in one received byte; on the closing byte works out the report.
   task automatic absorb_byte(input logic [7:0] b, input logic closing);
      frame_report_type rep;
      int               idx;
      int               cnt;
      int               dl;
      idx = fill;
      if (fill != COUNT_MAX) begin
         if (idx == 0) begin
            hdr_ok = (b == FRAME_HEADER);
         end else if (idx == 1) begin
            decl_len[15:8] = b;
         end else if (idx == 2) begin
            decl_len[7:0] = b;
         end
         if (idx == 3) begin
            cmd_byte = b;
         end
         if (idx >= 3 && idx <= int'(decl_len)) begin
            crc_acc = crc16_update(crc_acc, b);
         end
         if (idx >= CAPTURE_FIRST && idx < CAPTURE_FIRST + STATE_BYTES) begin
            capture[idx - CAPTURE_FIRST] = b;
         end
         fill = fill + 16'd1;
      end
      tail = {tail[7:0], b};
      if (closing) begin
         rep = '0;
         if (!hdr_ok) begin
            rep.status = STATUS_HEADER;
         end else begin
            cnt = fill;
            dl = decl_len;
            if (cnt >= 4) begin
               rep.command = cmd_byte;
            end
            if (dl >= 3) begin
               rep.data_length = 16'(dl - 3);
            end
            if (cnt < 3 || dl < 3 || cnt < dl + 3) begin
               rep.status = STATUS_LENGTH;
            end else if (crc_enable && crc_acc != tail) begin
               rep.status = STATUS_CRC;
            end else begin
               rep.status = STATUS_OK;
               if (cmd_byte == CMD_DEVICE_STATE) begin
                  if (dl - 3 >= STATE_BYTES) begin
                     state_rec = capture;
                     rep.state_updated = 1'b1;
                  end
               end else if (cmd_byte == CMD_OFFSET) begin
                  for (int k = 0; k < 3; k++) begin
                     offset_rec[k] = capture[k];
                  end
                  rep.offset_updated = 1'b1;
               end
            end
         end
         for (int k = 0; k < 8; k++) begin
            rep.state_low[k*8 +: 8] = state_rec[k];
         end
         rep.state_high = {state_rec[9], state_rec[8]};
         rep.offsets = {offset_rec[2], offset_rec[1], offset_rec[0]};
         expected_reports.push_back(rep);
         clear_frame();
      end
   endtask

   task automatic check_report();
      frame_report_type want;
      if (expected_reports.size() == 0) begin
         report_mismatch("report with none expected", '0, {62'b0, rsp_tuser});
      end else begin
         want = expected_reports.pop_front();
         if (rsp_tuser !== want.status)
            report_mismatch("frame_status", want.status, rsp_tuser);
         if (rsp_tdata[7:0] !== want.command)
            report_mismatch("command", want.command, rsp_tdata[7:0]);
         if (rsp_tdata[23:8] !== want.data_length)
            report_mismatch("data_length", want.data_length, rsp_tdata[23:8]);
         if (rsp_tdata[24] !== want.state_updated)
            report_mismatch("device_state_updated", want.state_updated, rsp_tdata[24]);
         if (rsp_tdata[25] !== want.offset_updated)
            report_mismatch("offset_updated", want.offset_updated, rsp_tdata[25]);
         if (rsp_tdata[89:26] !== want.state_low)
            report_mismatch("device_state_low", want.state_low, rsp_tdata[89:26]);
         if (rsp_tdata[105:90] !== want.state_high)
            report_mismatch("device_state_high", want.state_high, rsp_tdata[105:90]);
         if (rsp_tdata[129:106] !== want.offsets)
            report_mismatch("offset_xyz", want.offsets, rsp_tdata[129:106]);
      end
      reports_seen++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         crc_enable = 1'b1;
         clear_frame();
         for (int k = 0; k < STATE_BYTES; k++) begin
            capture[k] = '0;
            state_rec[k] = '0;
         end
         for (int k = 0; k < 3; k++) begin
            offset_rec[k] = '0;
         end
         expected_reports.delete();
         reports_seen = 0;
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            crc_enable = csr_data[0];
         end
         if (rsp_tvalid && rsp_tready) begin
            check_report();
         end
         if (req_tvalid && req_tready) begin
            absorb_byte(req_tdata, req_tlast);
         end
      end
      pending <= expected_reports.size();
   end

endmodule

// ===== tb/tb.sv =====
// Top of the command frame receiver testbench: clock, reset, frame stimulus
// and the final verdict. Depends on cfrc_pkg, the receiver and
// frame_report_checker, which does all prediction and comparison.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import cfrc_pkg::*;

   // Ways a generated burst departs from a well-formed frame.
   typedef enum int {
      FLAW_NONE,
      FLAW_CRC,        // one CRC bit flipped
      FLAW_HEADER,     // first byte is not the header
      FLAW_CUT,        // burst ends before the declared frame does
      FLAW_SHORT_LEN,  // declared length below the overhead
      FLAW_PADDED,     // extra bytes between the data and the CRC
      FLAW_STUB        // only the first one to three bytes
   } frame_flaw_type;

   localparam int IDLE_PCT       = 26;
   localparam int RANDOM_WORDS   = 1000;
   localparam int PHASES         = 4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int CSR_HOLDOFF    = 4;
   localparam int DRAIN_CYCLES   = 10;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [7:0]    req_tdata = '0;
   logic          req_tlast = 1'b0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [135:0]  rsp_tdata;
   logic [1:0]    rsp_tuser;
   logic          csr_valid = 1'b0;
   logic          csr_ready;
   logic [0:0]    csr_data = '0;

   int unsigned   mismatches;
   logic [31:0]   pending;

   int            idle_pct = IDLE_PCT;
   int            stall_count = 0;
   int            words_sent = 0;
   logic [7:0]    burst_q[$];

   command_frame_receiver_checker dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   frame_report_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .mismatches (mismatches),
      .pending    (pending)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The report side stalls at the same rate the byte side idles, so both
   // stretches with and without back-pressure come from one knob.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= idle_pct);
   end

   // Watchdog: any handshake on any channel counts as progress. A long run
   // of cycles with none means the block is hung or lost a report.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         stall_count <= 0;
      end else if (stall_count >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // Offers one word, with random idle cycles ahead of it, and returns at
   // the edge where it is taken. tvalid stays high afterward so that
   // back-to-back words need no second assignment in the same step.
   task automatic send_word(input logic [7:0] b, input logic closing);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      req_tlast <= closing;
      do @(posedge clock); while (!req_tready);
      words_sent++;
   endtask

   task automatic send_burst();
      for (int i = 0; i < burst_q.size(); i++) begin
         send_word(burst_q[i], i == burst_q.size() - 1);
      end
   endtask

   // Stops sending and waits until every report has come back. The pending
   // count is registered, hence the first wait. The hold-off after it
   // covers the parse stage before the control register moves.
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (CSR_HOLDOFF) @(posedge clock);
   endtask

   task automatic write_crc_enable(input logic en);
      csr_valid <= 1'b1;
      csr_data <= en;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   // Builds one burst into burst_q. A negative data_fill gives random data
   // bytes, otherwise every data byte takes that value.
   task automatic make_frame(input logic [7:0] cmd, input int n_data,
                             input frame_flaw_type flaw, input int data_fill);
      logic [15:0] len_field;
      logic [15:0] crc;
      logic [7:0]  b;
      int          keep;
      burst_q.delete();
      len_field = 16'(n_data + 3);
      if (flaw == FLAW_SHORT_LEN) begin
         len_field = 16'($urandom_range(2));
      end
      b = 8'($urandom);
      if (b == FRAME_HEADER) begin
         b = ~b;
      end
      burst_q.push_back((flaw == FLAW_HEADER) ? b : FRAME_HEADER);
      burst_q.push_back(len_field[15:8]);
      burst_q.push_back(len_field[7:0]);
      burst_q.push_back(cmd);
      crc = crc_xmodem_byte(16'h0000, cmd);
      for (int i = 0; i < n_data; i++) begin
         b = (data_fill < 0) ? 8'($urandom) : 8'(data_fill);
         burst_q.push_back(b);
         crc = crc_xmodem_byte(crc, b);
      end
      // Bytes past the declared frame are not covered by the CRC; the CRC
      // is still read from the last two bytes, so this frame stays good.
      if (flaw == FLAW_PADDED) begin
         repeat ($urandom_range(4, 1)) burst_q.push_back(8'($urandom));
      end
      if (flaw == FLAW_CRC) begin
         crc = crc ^ (16'h0001 << $urandom_range(15));
      end
      burst_q.push_back(crc[15:8]);
      burst_q.push_back(crc[7:0]);
      keep = burst_q.size();
      if (flaw == FLAW_CUT) begin
         keep = $urandom_range(burst_q.size() - 1, 3);
      end else if (flaw == FLAW_STUB) begin
         keep = $urandom_range(3, 1);
      end
      while (burst_q.size() > keep) begin
         b = burst_q.pop_back();
      end
   endtask

   // Line noise: random bytes, sometimes opening with a header byte.
   task automatic make_noise();
      int n;
      burst_q.delete();
      n = $urandom_range(20, 1);
      for (int i = 0; i < n; i++) begin
         burst_q.push_back(8'($urandom));
      end
      if ($urandom_range(1)) begin
         burst_q[0] = FRAME_HEADER;
      end
   endtask

   // One random burst. Most are well-formed frames with random content, so
   // the record updates and the CRC path see plenty of traffic.
   task automatic random_burst();
      logic [7:0]     cmd;
      int             n_data;
      int             roll;
      frame_flaw_type flaw;
      case ($urandom_range(2))
         0: begin
            cmd = CMD_DEVICE_STATE;
            n_data = $urandom_range(14, 8);
         end
         1: begin
            cmd = CMD_OFFSET;
            n_data = $urandom_range(5, 0);
         end
         default: begin
            cmd = 8'($urandom);
            n_data = $urandom_range(12, 0);
         end
      endcase
      roll = $urandom_range(99);
      if (roll < 60)       flaw = FLAW_NONE;
      else if (roll < 72)  flaw = FLAW_CRC;
      else if (roll < 80)  flaw = FLAW_CUT;
      else if (roll < 85)  flaw = FLAW_HEADER;
      else if (roll < 89)  flaw = FLAW_SHORT_LEN;
      else if (roll < 95)  flaw = FLAW_PADDED;
      else                 flaw = FLAW_STUB;
      if (roll >= 98) begin
         make_noise();
      end else begin
         make_frame(cmd, n_data, flaw, -1);
      end
      send_burst();
   endtask

   initial begin
      int phase_start;

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      write_crc_enable(1'b1);

      // Directed part. The first burst is long enough to write every entry
      // of the data capture, so a short offset frame later never reads an
      // entry that was never written.
      make_frame(CMD_DEVICE_STATE, 10, FLAW_NONE, -1);
      send_burst();
      make_frame(CMD_OFFSET, 3, FLAW_NONE, 8'hFF);
      send_burst();
      // Offset frame with no data: x and y take its CRC bytes, z comes from earlier bursts.
      make_frame(CMD_OFFSET, 0, FLAW_NONE, -1);
      send_burst();
      // One byte short of a device-state update.
      make_frame(CMD_DEVICE_STATE, 9, FLAW_NONE, 8'h00);
      send_burst();
      make_frame(CMD_DEVICE_STATE, 11, FLAW_NONE, 8'hFF);
      send_burst();
      make_frame(8'h00, 0, FLAW_NONE, -1);
      send_burst();
      make_frame(8'hFF, 2, FLAW_NONE, 8'h00);
      send_burst();
      make_frame(CMD_OFFSET, 3, FLAW_HEADER, -1);
      send_burst();
      // Bursts of one, two and three bytes.
      burst_q.delete();
      burst_q.push_back(FRAME_HEADER);
      send_burst();
      burst_q.push_back(8'h00);
      send_burst();
      burst_q.push_back(8'h03);
      send_burst();
      make_frame(CMD_DEVICE_STATE, 10, FLAW_CUT, -1);
      send_burst();
      make_frame(CMD_OFFSET, 3, FLAW_SHORT_LEN, -1);
      send_burst();
      make_frame(CMD_OFFSET, 3, FLAW_CRC, -1);
      send_burst();
      make_frame(CMD_OFFSET, 3, FLAW_PADDED, -1);
      send_burst();

      // With checking off a corrupted CRC must still pass and update.
      settle();
      write_crc_enable(1'b0);
      make_frame(CMD_DEVICE_STATE, 10, FLAW_CRC, -1);
      send_burst();
      make_frame(CMD_OFFSET, 4, FLAW_CRC, -1);
      send_burst();

      // Random phases, each under its own CRC setting. The second phase has
      // no idling on either side at all.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0:       write_crc_enable(1'b1);
            1:       write_crc_enable(1'b0);
            2:       write_crc_enable(1'($urandom_range(1)));
            default: write_crc_enable(1'b1);
         endcase
         idle_pct <= (phase == 1) ? 0 : IDLE_PCT;
         phase_start = words_sent;
         while (words_sent - phase_start < RANDOM_WORDS / PHASES) begin
            random_burst();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/cfrc_pkg.sv
src/cfrc_parser.sv
src/command_frame_receiver_checker.sv
src/cfrc_checker.sv
tb/frame_report_checker.sv
tb/tb.sv
